### rtl/core/ssa_pkg.sv
// Shared types and constants for the SPI sensor sample accumulator.
// No dependencies; the interfaces and the top level refer to it by scoped names.
package ssa_pkg;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 32;
   localparam int TOTAL_W     = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int XFER_W      = 3;
   localparam int FLAGS_W     = 2;
   localparam int SHIFT_W     = 5;
   localparam int CENTER_W    = 31;
   localparam int DEAD_W      = 30;

   localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TRANSFER_BYTES = 3'd0,
      REG_FORMAT_FLAGS   = 3'd1,
      REG_VALID_MASK     = 3'd2,
      REG_VALID_PATTERN  = 3'd3,
      REG_FIELD_SHIFT    = 3'd4,
      REG_FIELD_BITS     = 3'd5,
      REG_CENTER_OFFSET  = 3'd6,
      REG_DEAD_ZONE      = 3'd7
   } csr_index_type;

   localparam int FLAG_BIG_ENDIAN = 0;
   localparam int FLAG_SIGNED     = 1;

   typedef struct packed {
      logic              clear;
      logic              valid;
      logic              sum;
      logic [WORD_W-1:0] sample;
   } sample_type;

endpackage

### rtl/core/ssa_if.sv
// Request, response and register-write channel interfaces of the accumulator.
// Depends on ssa_pkg for field widths.
interface ssa_req_if;
   logic                           valid;
   logic                           ready;
   logic                           func;
   logic [ssa_pkg::BYTE_W-1:0]     resp_byte0;
   logic [ssa_pkg::BYTE_W-1:0]     resp_byte1;
   logic [ssa_pkg::BYTE_W-1:0]     resp_byte2;
   logic [ssa_pkg::BYTE_W-1:0]     resp_byte3;
   modport source (output valid, func, resp_byte0, resp_byte1, resp_byte2, resp_byte3,
                   input ready);
   modport sink (input valid, func, resp_byte0, resp_byte1, resp_byte2, resp_byte3,
                 output ready);
endinterface

interface ssa_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ssa_pkg::TOTAL_W-1:0] total;
   logic [ssa_pkg::WORD_W-1:0]         sample_count;
   logic signed [ssa_pkg::WORD_W-1:0]  last_sample;
   logic                               sample_valid;
   modport source (output valid, total, sample_count, last_sample, sample_valid,
                   input ready);
   modport sink (input valid, total, sample_count, last_sample, sample_valid,
                 output ready);
endinterface

interface ssa_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ssa_pkg::CSR_INDEX_W-1:0]   index;
   logic [ssa_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/spi_sensor_sample_accumulator.sv
// Top level of the SPI sensor sample accumulator: word assembly, field
// extraction, centering, deadband test and the running total, count and last value.
// Depends on ssa_pkg and the channel interfaces in ssa_if.sv.
//
//   channel  direction  carries
//   req      in         func, resp_byte0..resp_byte3
//   rsp      out        total, sample_count, last_sample, sample_valid
//   csr      in         index, data (register write)
//
// One request per cycle unless a stalled response backs up the stages; each request passes
// through the input register, sample register and accumulator/result register.
// Each stage holds its item only while the stage after it is full and stalled,
// so requests keep flowing into empty stages while a response waits.
// The register-write port is always ready. Reset is synchronous and clears
// the stage valid bits, the totals and the registers to their reset values.
module spi_sensor_sample_accumulator (
   input logic       clock,
   input logic       reset,
   ssa_req_if.sink   req,
   ssa_rsp_if.source rsp,
   ssa_csr_if.sink   csr
);

   logic [ssa_pkg::XFER_W-1:0]   transfer_bytes_ff;
   logic [ssa_pkg::FLAGS_W-1:0]  format_flags_ff;
   logic [ssa_pkg::WORD_W-1:0]   valid_mask_ff;
   logic [ssa_pkg::WORD_W-1:0]   valid_pattern_ff;
   logic [ssa_pkg::SHIFT_W-1:0]  field_shift_ff;
   logic [ssa_pkg::SHIFT_W-1:0]  field_bits_ff;
   logic [ssa_pkg::CENTER_W-1:0] center_offset_ff;
   logic [ssa_pkg::DEAD_W-1:0]   dead_zone_ff;

   logic                                s1_valid_ff;
   logic                                s1_func_ff;
   logic [3:0][ssa_pkg::BYTE_W-1:0]     s1_bytes_ff;
   logic                                s2_valid_ff;
   ssa_pkg::sample_type                 s2_ff;
   ssa_pkg::sample_type                 s2_in;
   logic                                out_valid_ff;
   logic signed [ssa_pkg::TOTAL_W-1:0]  total_ff;
   logic signed [ssa_pkg::TOTAL_W-1:0]  total_in;
   logic [ssa_pkg::WORD_W-1:0]          count_ff;
   logic [ssa_pkg::WORD_W-1:0]          count_in;
   logic [ssa_pkg::WORD_W-1:0]          last_ff;
   logic [ssa_pkg::WORD_W-1:0]          last_in;
   logic                                sample_valid_ff;
   logic                                sample_valid_in;

   logic en1;
   logic en2;
   logic en3;

   logic [ssa_pkg::WORD_W-1:0] word;
   logic [ssa_pkg::WORD_W-1:0] shifted;
   logic [ssa_pkg::WORD_W-1:0] fmask;
   logic [ssa_pkg::WORD_W-1:0] field;
   logic [ssa_pkg::WORD_W-1:0] field_ext;
   logic [ssa_pkg::WORD_W-1:0] center32;
   logic [ssa_pkg::WORD_W-1:0] diff;
   logic                       sign_hit;
   logic signed [ssa_pkg::WORD_W:0] s_ext;
   logic signed [ssa_pkg::WORD_W:0] dz_ext;

   assign en3 = !out_valid_ff || rsp.ready;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req.ready = en1;
   assign csr.ready = 1'b1;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         transfer_bytes_ff <= 3'd4;
         format_flags_ff   <= '0;
         valid_mask_ff     <= '0;
         valid_pattern_ff  <= '0;
         field_shift_ff    <= '0;
         field_bits_ff     <= 5'd16;
         center_offset_ff  <= '0;
         dead_zone_ff      <= '0;
      end else if (csr.valid) begin
         case (ssa_pkg::csr_index_type'(csr.index))
            ssa_pkg::REG_TRANSFER_BYTES: transfer_bytes_ff <= csr.data[ssa_pkg::XFER_W-1:0];
            ssa_pkg::REG_FORMAT_FLAGS:   format_flags_ff   <= csr.data[ssa_pkg::FLAGS_W-1:0];
            ssa_pkg::REG_VALID_MASK:     valid_mask_ff     <= csr.data;
            ssa_pkg::REG_VALID_PATTERN:  valid_pattern_ff  <= csr.data;
            ssa_pkg::REG_FIELD_SHIFT:    field_shift_ff    <= csr.data[ssa_pkg::SHIFT_W-1:0];
            ssa_pkg::REG_FIELD_BITS:     field_bits_ff     <= csr.data[ssa_pkg::SHIFT_W-1:0];
            ssa_pkg::REG_CENTER_OFFSET:  center_offset_ff  <= csr.data[ssa_pkg::CENTER_W-1:0];
            ssa_pkg::REG_DEAD_ZONE:      dead_zone_ff      <= csr.data[ssa_pkg::DEAD_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req.valid) begin
         s1_func_ff     <= req.func;
         s1_bytes_ff[0] <= req.resp_byte0 & ssa_pkg::BYTE_MASK;
         s1_bytes_ff[1] <= req.resp_byte1 & ssa_pkg::BYTE_MASK;
         s1_bytes_ff[2] <= req.resp_byte2 & ssa_pkg::BYTE_MASK;
         s1_bytes_ff[3] <= req.resp_byte3 & ssa_pkg::BYTE_MASK;
      end
   end

   // Word assembly; lengths above four act as four.
   always_comb begin
      if (format_flags_ff[ssa_pkg::FLAG_BIG_ENDIAN]) begin
         case (transfer_bytes_ff)
            3'd0:    word = '0;
            3'd1:    word = {24'd0, s1_bytes_ff[0]};
            3'd2:    word = {16'd0, s1_bytes_ff[0], s1_bytes_ff[1]};
            3'd3:    word = {8'd0, s1_bytes_ff[0], s1_bytes_ff[1], s1_bytes_ff[2]};
            default: word = {s1_bytes_ff[0], s1_bytes_ff[1], s1_bytes_ff[2], s1_bytes_ff[3]};
         endcase
      end else begin
         case (transfer_bytes_ff)
            3'd0:    word = '0;
            3'd1:    word = {24'd0, s1_bytes_ff[0]};
            3'd2:    word = {16'd0, s1_bytes_ff[1], s1_bytes_ff[0]};
            3'd3:    word = {8'd0, s1_bytes_ff[2], s1_bytes_ff[1], s1_bytes_ff[0]};
            default: word = {s1_bytes_ff[3], s1_bytes_ff[2], s1_bytes_ff[1], s1_bytes_ff[0]};
         endcase
      end
   end

   // Field extraction, sign extension, centering and the deadband test.
   always_comb begin
      shifted   = word >> field_shift_ff;
      fmask     = ~({ssa_pkg::WORD_W{1'b1}} << field_bits_ff);
      field     = shifted & fmask;
      sign_hit  = format_flags_ff[ssa_pkg::FLAG_SIGNED] && (|(field & fmask & ~(fmask >> 1)));
      field_ext = sign_hit ? (field | ~fmask) : field;
      center32  = {center_offset_ff[ssa_pkg::CENTER_W-1], center_offset_ff};
      diff      = field_ext - center32;
      s_ext     = $signed({diff[ssa_pkg::WORD_W-1], diff});
      dz_ext    = $signed({3'd0, dead_zone_ff});
      s2_in.clear  = s1_func_ff;
      s2_in.valid  = !s1_func_ff && ((word & valid_mask_ff) == valid_pattern_ff);
      s2_in.sum    = (s_ext > dz_ext) || (s_ext < -dz_ext);
      s2_in.sample = diff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   // Accumulator and result register.
   always_comb begin
      total_in        = total_ff;
      count_in        = count_ff;
      last_in         = '0;
      sample_valid_in = 1'b0;
      if (s2_ff.clear) begin
         total_in = '0;
         count_in = '0;
      end else if (s2_ff.valid) begin
         if (s2_ff.sum) begin
            total_in = total_ff + $signed({{(ssa_pkg::TOTAL_W-ssa_pkg::WORD_W)
                                             {s2_ff.sample[ssa_pkg::WORD_W-1]}},
                                           s2_ff.sample});
         end
         count_in        = count_ff + 32'd1;
         last_in         = s2_ff.sample;
         sample_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         total_ff        <= '0;
         count_ff        <= '0;
         last_ff         <= '0;
         sample_valid_ff <= 1'b0;
      end else if (en3) begin
         out_valid_ff <= s2_valid_ff;
         if (s2_valid_ff) begin
            total_ff        <= total_in;
            count_ff        <= count_in;
            last_ff         <= last_in;
            sample_valid_ff <= sample_valid_in;
         end
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.total        = total_ff;
   assign rsp.sample_count = count_ff;
   assign rsp.last_sample  = $signed(last_ff);
   assign rsp.sample_valid = sample_valid_ff;

   // A valid sample loaded into the result register advances the count by one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (en3 && s2_valid_ff && !s2_ff.clear && s2_ff.valid) |=>
         (count_ff == $past(count_ff) + 32'd1))
      else $error("sample count did not advance by one");

   // A clear request empties the total and the count.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (en3 && s2_valid_ff && s2_ff.clear) |=> (total_ff == '0 && count_ff == '0))
      else $error("clear request left a nonzero total or count");

   // A response without a valid sample always reports a zero last value.
   a_last_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !sample_valid_ff) |-> (last_ff == '0))
      else $error("last value nonzero without a valid sample");

   // An empty input stage takes a request even while a response is stalled.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req.ready)
      else $error("input stage empty but not ready");

endmodule

### test/ssa_accumulator_checker.sv
// Response checker for the SPI sensor sample accumulator: watches the request, response
// and register-write channels, predicts every response and compares it field by field.
// Depends on ssa_pkg and the channel interfaces in ssa_if.sv.
module ssa_accumulator_checker (
   input  logic        clock,
   input  logic        reset,
   ssa_req_if          req,
   ssa_rsp_if          rsp,
   ssa_csr_if          csr,
   output int unsigned error_count,
   output int unsigned outstanding
);
   import ssa_pkg::*;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [WORD_W-1:0]  count;
      logic [WORD_W-1:0]  last;
      logic               valid;
   } reading_type;

   logic [XFER_W-1:0]   xfer_bytes;
   logic [FLAGS_W-1:0]  format;
   logic [WORD_W-1:0]   match_mask;
   logic [WORD_W-1:0]   match_pattern;
   logic [SHIFT_W-1:0]  field_shift;
   logic [SHIFT_W-1:0]  field_width;
   logic [CENTER_W-1:0] center;
   logic [DEAD_W-1:0]   dead_band;

   logic [TOTAL_W-1:0]  running_sum;
   logic [WORD_W-1:0]   sample_tally;
   logic [WORD_W-1:0]   latest;

   reading_type         pending_readings[$];

   task automatic restore_defaults();
      xfer_bytes    = 3'd4;
      format        = '0;
      match_mask    = '0;
      match_pattern = '0;
      field_shift   = '0;
      field_width   = 5'd16;
      center        = '0;
      dead_band     = '0;
      running_sum   = '0;
      sample_tally  = '0;
      latest        = '0;
   endtask

   task automatic apply_write(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      case (idx)
         REG_TRANSFER_BYTES: xfer_bytes    = value[XFER_W-1:0];
         REG_FORMAT_FLAGS:   format        = value[FLAGS_W-1:0];
         REG_VALID_MASK:     match_mask    = value;
         REG_VALID_PATTERN:  match_pattern = value;
         REG_FIELD_SHIFT:    field_shift   = value[SHIFT_W-1:0];
         REG_FIELD_BITS:     field_width   = value[SHIFT_W-1:0];
         REG_CENTER_OFFSET:  center        = value[CENTER_W-1:0];
         REG_DEAD_ZONE:      dead_band     = value[DEAD_W-1:0];
         default: ;
      endcase
   endtask

   function automatic reading_type accumulate(input logic func, input logic [BYTE_W-1:0] b0,
                                              input logic [BYTE_W-1:0] b1,
                                              input logic [BYTE_W-1:0] b2,
                                              input logic [BYTE_W-1:0] b3);
      logic [BYTE_W-1:0] bytes [4];
      logic [WORD_W-1:0] word;
      logic [WORD_W-1:0] fmask;
      logic [WORD_W-1:0] val;
      logic [WORD_W-1:0] center32;
      longint            centered;
      longint            band;
      int                n;
      reading_type       r;
      r.valid = 1'b0;
      if (func) begin
         running_sum  = '0;
         sample_tally = '0;
         latest       = '0;
      end else begin
         bytes[0] = b0;
         bytes[1] = b1;
         bytes[2] = b2;
         bytes[3] = b3;
         n = (xfer_bytes > 4) ? 4 : int'(xfer_bytes);
         word = '0;
         if (format[FLAG_BIG_ENDIAN]) begin
            for (int i = 0; i < n; i++) word = (word << BYTE_W) | WORD_W'(bytes[i]);
         end else begin
            for (int i = n; i > 0; i--) word = (word << BYTE_W) | WORD_W'(bytes[i-1]);
         end
         if ((word & match_mask) == match_pattern) begin
            fmask = (field_width == 0) ? '0 : WORD_W'((64'd1 << field_width) - 64'd1);
            val = (word >> field_shift) & fmask;
            if (format[FLAG_SIGNED] && field_width != 0 && val[field_width-1]) val |= ~fmask;
            center32 = {center[CENTER_W-1], center};
            val = val - center32;
            centered = longint'(signed'(val));
            band = longint'(dead_band);
            if (centered < -band || centered > band) running_sum = running_sum + centered;
            sample_tally = sample_tally + 1'b1;
            latest = val;
            r.valid = 1'b1;
         end else begin
            latest = '0;
         end
      end
      r.total = running_sum;
      r.count = sample_tally;
      r.last  = latest;
      return r;
   endfunction

   task automatic compare_response();
      reading_type got;
      reading_type want;
      got = {rsp.total, rsp.sample_count, rsp.last_sample, rsp.sample_valid};
      if (pending_readings.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("unexpected response: total %0d count %0d last %0d valid %0b",
                     $signed(got.total), got.count, $signed(got.last), got.valid);
         return;
      end
      want = pending_readings.pop_front();
      if (got.total !== want.total || got.count !== want.count ||
          got.last !== want.last || got.valid !== want.valid) begin
         error_count++;
         if (error_count <= 10)
            $display("response mismatch: total %0d/%0d count %0d/%0d last %0d/%0d valid %0b/%0b",
                     $signed(want.total), $signed(got.total), want.count, got.count,
                     $signed(want.last), $signed(got.last), want.valid, got.valid);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
         pending_readings.delete();
         error_count = 0;
         outstanding <= 0;
      end else begin
         if (csr.valid && csr.ready) apply_write(csr_index_type'(csr.index), csr.data);
         if (rsp.valid && rsp.ready) compare_response();
         if (req.valid && req.ready)
            pending_readings.push_back(accumulate(req.func, req.resp_byte0, req.resp_byte1,
                                                  req.resp_byte2, req.resp_byte3));
         outstanding <= pending_readings.size();
      end
   end

endmodule

### test/testbench.sv
// Top of the accumulator testbench: clock, reset, request and register-write stimulus
// and the final verdict. Depends on ssa_pkg, ssa_if.sv, the accumulator top level and
// the response checker in ssa_accumulator_checker.sv.
module testbench;
   import ssa_pkg::*;

   localparam logic [FLAGS_W-1:0] ORDER_BIG    = FLAGS_W'(1 << FLAG_BIG_ENDIAN);
   localparam logic [FLAGS_W-1:0] FIELD_SIGNED = FLAGS_W'(1 << FLAG_SIGNED);

   typedef struct {
      logic [XFER_W-1:0]   xfer;
      logic [FLAGS_W-1:0]  flags;
      logic [WORD_W-1:0]   mask;
      logic [WORD_W-1:0]   pattern;
      logic [SHIFT_W-1:0]  shift;
      logic [SHIFT_W-1:0]  bits;
      logic [CENTER_W-1:0] center;
      logic [DEAD_W-1:0]   dead;
   } settings_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   int unsigned  error_count;
   int unsigned  outstanding;
   int           idle_pct = 0;
   int           stall_pct = 0;
   int           hold_cycles = 0;
   settings_type cfg;

   ssa_req_if req_ch();
   ssa_rsp_if rsp_ch();
   ssa_csr_if csr_ch();

   spi_sensor_sample_accumulator dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   ssa_accumulator_checker accumulator_check (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr         (csr_ch),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("testbench NOT OK");
      $finish;
   end

   // The response side stalls at random, or for a counted stretch when asked to.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ch.ready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send(input logic func, input logic [BYTE_W-1:0] b0,
                       input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2,
                       input logic [BYTE_W-1:0] b3);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.func       = func;
      req_ch.resp_byte0 = b0;
      req_ch.resp_byte1 = b1;
      req_ch.resp_byte2 = b2;
      req_ch.resp_byte3 = b3;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Packs a word into the response bytes the way the current byte order expects it,
   // optionally forcing the masked bits to the valid pattern.
   task automatic send_word(input logic [WORD_W-1:0] seed, input bit conform);
      logic [WORD_W-1:0] w;
      logic [BYTE_W-1:0] b [4];
      int                n;
      n = (cfg.xfer > 4) ? 4 : int'(cfg.xfer);
      w = conform ? ((seed & ~cfg.mask) | cfg.pattern) : seed;
      for (int i = 0; i < 4; i++) b[i] = BYTE_W'($urandom);
      for (int i = 0; i < n; i++) begin
         if (cfg.flags[FLAG_BIG_ENDIAN]) b[i] = w[BYTE_W*(n-1-i) +: BYTE_W];
         else b[i] = w[BYTE_W*i +: BYTE_W];
      end
      send(1'b0, b[0], b[1], b[2], b[3]);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic program_settings(input settings_type s);
      write_reg(REG_TRANSFER_BYTES, CSR_DATA_W'(s.xfer));
      write_reg(REG_FORMAT_FLAGS, CSR_DATA_W'(s.flags));
      write_reg(REG_VALID_MASK, s.mask);
      write_reg(REG_VALID_PATTERN, s.pattern);
      write_reg(REG_FIELD_SHIFT, CSR_DATA_W'(s.shift));
      write_reg(REG_FIELD_BITS, CSR_DATA_W'(s.bits));
      write_reg(REG_CENTER_OFFSET, {s.center[CENTER_W-1], s.center});
      write_reg(REG_DEAD_ZONE, CSR_DATA_W'(s.dead));
      cfg = s;
   endtask

   task automatic settle();
      req_ch.valid = 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   function automatic settings_type pick_settings();
      settings_type      s;
      logic [WORD_W-1:0] span;
      int                n;
      case ($urandom_range(9))
         0:       s.xfer = 3'd0;
         1:       s.xfer = XFER_W'($urandom_range(7, 5));
         default: s.xfer = XFER_W'($urandom_range(4, 1));
      endcase
      s.flags = FLAGS_W'($urandom_range(3));
      n = (s.xfer > 4) ? 4 : int'(s.xfer);
      span = (n == 4) ? '1 : (32'd1 << (BYTE_W * n)) - 32'd1;
      case ($urandom_range(3))
         0:       s.mask = '0;
         1:       s.mask = $urandom & span;
         2:       s.mask = '1;
         default: s.mask = $urandom;
      endcase
      s.pattern = $urandom & s.mask;
      if ($urandom_range(7) != 0) s.pattern &= span;
      s.shift = SHIFT_W'(($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(12));
      case ($urandom_range(9))
         0:       s.bits = 5'd0;
         1:       s.bits = 5'd31;
         default: s.bits = SHIFT_W'($urandom_range(30, 1));
      endcase
      case ($urandom_range(4))
         0:       s.center = '0;
         1:       s.center = 31'h4000_0000;
         2:       s.center = 31'h3fff_ffff;
         3:       s.center = CENTER_W'($urandom_range(2000)) - 31'd1000;
         default: s.center = CENTER_W'($urandom);
      endcase
      case ($urandom_range(3))
         0:       s.dead = '0;
         1:       s.dead = '1;
         2:       s.dead = DEAD_W'($urandom_range(3000));
         default: s.dead = DEAD_W'($urandom);
      endcase
      return s;
   endfunction

   task automatic random_request();
      logic [WORD_W-1:0] seed;
      int                pick;
      pick = $urandom_range(99);
      seed = $urandom;
      if ($urandom_range(15) == 0) seed = $urandom_range(1) ? '0 : '1;
      if (pick < 5) send(1'b1, BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                         BYTE_W'($urandom));
      else if (pick < 78) send_word(seed, 1'b1);
      else send_word(seed, 1'b0);
   endtask

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.func       = 1'b0;
      req_ch.resp_byte0 = '0;
      req_ch.resp_byte1 = '0;
      req_ch.resp_byte2 = '0;
      req_ch.resp_byte3 = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = REG_TRANSFER_BYTES;
      csr_ch.data       = '0;
      cfg = '{3'd4, '0, '0, '0, '0, 5'd16, '0, '0};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Settings after reset: every four-byte little-endian word is valid.
      send(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
      send(1'b0, 8'hff, 8'hff, 8'hff, 8'hff);
      send(1'b0, 8'h55, 8'haa, 8'h55, 8'haa);
      send(1'b0, 8'haa, 8'h55, 8'haa, 8'h55);
      send(1'b0, 8'h00, 8'h80, 8'h00, 8'h00);
      send(1'b1, 8'hff, 8'hff, 8'hff, 8'hff);
      send(1'b0, 8'h01, 8'h02, 8'h03, 8'h04);

      // A zero transfer length packs nothing, so the word is zero.
      settle();
      program_settings('{3'd0, ORDER_BIG | FIELD_SIGNED, '1, '0, '0, 5'd31,
                         31'h4000_0000, 30'h3fff_ffff});
      send(1'b0, 8'h12, 8'h34, 8'h56, 8'h78);
      send(1'b0, 8'hff, 8'hff, 8'hff, 8'hff);

      // A length above four acts as four; a zero-width field reads as zero.
      settle();
      program_settings('{3'd7, ORDER_BIG, '1, 32'h1234_5678, 5'd31, 5'd0,
                         31'h3fff_ffff, '0});
      send(1'b0, 8'h12, 8'h34, 8'h56, 8'h78);
      send(1'b0, 8'h12, 8'h34, 8'h56, 8'h79);
      send(1'b0, 8'h78, 8'h56, 8'h34, 8'h12);

      // A signed 31-bit field with a centering offset.
      settle();
      program_settings('{3'd4, FIELD_SIGNED, '0, '0, '0, 5'd31, 31'h3fff_ffff, '0});
      send(1'b0, 8'hff, 8'hff, 8'hff, 8'h7f);
      send(1'b0, 8'h00, 8'h00, 8'h00, 8'h40);
      send(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
      send(1'b0, 8'hff, 8'hff, 8'hff, 8'h3f);

      // Samples on both edges of the dead zone, and an invalid word.
      settle();
      program_settings('{3'd1, FIELD_SIGNED, 32'h0000_00f0, '0, '0, 5'd4, '0, 30'd3});
      send(1'b0, 8'h03, 8'hff, 8'hff, 8'hff);
      send(1'b0, 8'h04, 8'h00, 8'h00, 8'h00);
      send(1'b0, 8'h0d, 8'h00, 8'h00, 8'h00);
      send(1'b0, 8'h0c, 8'h00, 8'h00, 8'h00);
      send(1'b0, 8'h13, 8'h00, 8'h00, 8'h00);

      for (int phase = 0; phase < 10; phase++) begin
         settle();
         idle_pct  = (phase % 4 == 1) ? 57 : (phase % 4 == 3) ? 22 : 0;
         stall_pct = (phase % 4 == 2) ? 57 : (phase % 4 == 3) ? 22 : 0;
         program_settings(pick_settings());
         for (int k = 0; k < 75; k++) begin
            if (phase == 4 && k == 10) hold_cycles = 80;
            if (phase == 6 && k == 40) settle();
            random_request();
         end
      end

      settle();
      repeat (10) @(negedge clock);
      if (error_count == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule
